### rtl/core/timed_step_sequencer_macros.svh
// Assertion macros for the timed step sequencer RTL.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef TIMED_STEP_SEQUENCER_MACROS_SVH
`define TIMED_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timed_step_sequencer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timed_step_sequencer: next-cycle check failed");

`endif

### rtl/core/tss_pkg.sv
// Shared types, constants and helper functions for the timed step sequencer.
// No dependencies; imported by tss_step_table and timed_step_sequencer.
`default_nettype none

package tss_pkg;

    // Table and field sizes
    localparam int MAX_STEPS = 16;
    localparam int SLOT_W    = $clog2(MAX_STEPS);
    localparam int COUNT_W   = $clog2(MAX_STEPS + 1);
    localparam int TAG_COUNT = 64;
    localparam int TAG_W     = 6;
    localparam int DUR_W     = 32;
    localparam int VOL_W     = 5;
    localparam int PCT_W     = 7;
    localparam int LEVEL_W   = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Reset values and limits
    localparam logic [VOL_W-1:0] VOLUME_RESET    = VOL_W'(10);
    localparam logic [PCT_W-1:0] START_PCT_RESET = PCT_W'(33);
    localparam logic [PCT_W-1:0] PCT_MAX         = PCT_W'(100);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VOLUME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_READY = 2'd2;

    // What an input beat asks for
    typedef enum logic [1:0] {
        ITEM_TICK  = 2'd0,
        ITEM_START = 2'd1,
        ITEM_STOP  = 2'd2,
        ITEM_WRITE = 2'd3
    } item_kind_t;

    // Kind of one table step
    typedef enum logic [1:0] {
        STEP_PAUSE   = 2'd0,
        STEP_SOUND   = 2'd1,
        STEP_ULTRA   = 2'd2,
        STEP_INVALID = 2'd3
    } step_kind_t;

    // One step table entry
    typedef struct packed {
        step_kind_t         kind;
        logic [TAG_W-1:0]   tag;
        logic [DUR_W-1:0]   duration;
    } step_entry_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [SLOT_W-1:0]  current_step;
        logic               running;
        logic               accepted;
        logic [DUR_W-1:0]   play_duration;
        logic [LEVEL_W-1:0] ultrasound_level;
        logic [TAG_W-1:0]   sound_tag;
        logic [VOL_W-1:0]   volume_level;
        logic               set_volume;
        logic               play_ultrasound;
        logic               play_sound;
        logic               stop_player;
        logic               stop_ultrasound;
    } result_t;

    // Player volume (0..30) = round(pct * 30 / 100), pct clamped to 100.
    // Divide by 100 as multiply by 5243 / 2^19; exact for sums up to 3050.
    function automatic logic [VOL_W-1:0] pct_to_volume(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] p;
        logic [11:0]      num;
        logic [24:0]      prod;
        p    = (pct > PCT_MAX) ? PCT_MAX : pct;
        num  = 12'(p) * 12'd30 + 12'd50;
        prod = 25'(num) * 25'd5243;
        return prod[23:19];
    endfunction

    // Ultrasound level = round(round(vol * 100 / 30) / 10), which reduces
    // to floor((vol + 1) / 3); divide by 3 as multiply by 171 / 2^9.
    function automatic logic [LEVEL_W-1:0] volume_to_level(input logic [VOL_W-1:0] vol);
        logic [VOL_W:0] x;
        logic [13:0]    prod;
        x    = {1'b0, vol} + (VOL_W+1)'(1);
        prod = 14'(x) * 14'd171;
        return prod[12:9];
    endfunction

endpackage

`default_nettype wire

### rtl/core/tss_step_table.sv
// Step table storage: kind, tag and duration for each slot.
// One write port, one combinational read port; no reset. Uses tss_pkg.
`default_nettype none

module tss_step_table
    import tss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_slot,
    input  wire step_entry_t       wr_entry,
    input  wire logic [SLOT_W-1:0] rd_slot,
    output step_entry_t            rd_entry
);

    step_entry_t entry_reg [MAX_STEPS];

    // Slot write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_slot] <= wr_entry;
        end
    end

    // Read at the current step
    assign rd_entry = entry_reg[rd_slot];

endmodule

`default_nettype wire

### rtl/core/timed_step_sequencer.sv
// Top level of the timed step sequencer: state update, config and output stage.
// Depends on tss_pkg, tss_step_table and timed_step_sequencer_macros.svh.
`default_nettype none

// Looping step sequencer. Each input beat (tick, start, stop or step write)
// updates the sequencer state and produces exactly one result
// beat, which appears on the m_ side the cycle after acceptance. A beat is
// taken every cycle as long as the result register is empty or being drained
// in the same cycle, so sustained throughput is one item per clock; the single
// pass through the state update logic into the result register sets this.
// Configuration writes are taken at any time but must only be issued while
// no result is pending. The step table has no reset: write every slot below
// step_count before starting.

`include "timed_step_sequencer_macros.svh"

module timed_step_sequencer
    import tss_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [3:0] step_slot, [5:4] step_kind, [11:6] step_tag, [43:12] step_duration
    input  wire logic [47:0]          s_tdata,
    // [1:0] kind
    input  wire logic [1:0]           s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] stop_ultrasound, [1] stop_player, [2] play_sound, [3] play_ultrasound,
    // [4] set_volume, [9:5] volume_level, [15:10] sound_tag,
    // [19:16] ultrasound_level, [51:20] play_duration, [52] accepted,
    // [53] running, [57:54] current_step
    output logic [63:0]               m_tdata
);

    localparam int RES_W = $bits(result_t);

    // Configuration registers
    logic [COUNT_W-1:0] step_count_reg;
    logic [PCT_W-1:0]   start_pct_reg;
    logic               player_ready_reg;

    // Sequencer state
    logic               running_reg, running_next;
    logic               active_reg, active_next;
    logic [SLOT_W-1:0]  step_idx_reg, step_idx_next;
    logic [DUR_W-1:0]   elapsed_reg, elapsed_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;
    logic [MAX_STEPS-1:0] sound_mask_reg, sound_mask_next;

    // Output stage
    logic               m_tvalid_reg;
    result_t            res_reg;
    result_t            res;

    // Input fields
    item_kind_t         in_kind;
    logic [SLOT_W-1:0]  in_slot;
    step_kind_t         in_step_kind;
    logic [TAG_W-1:0]   in_tag;
    logic [DUR_W-1:0]   in_duration;
    logic               s_fire;

    // Working signals
    logic [COUNT_W-1:0] eff_count;
    logic [SLOT_W-1:0]  tick_idx;
    logic [COUNT_W-1:0] idx_inc;
    logic [DUR_W-1:0]   el_cur;
    logic               needs_player;
    logic               start_ok;
    logic               start_refused;
    logic               write_ok;
    logic               tag_known;
    logic               wr_en;
    step_entry_t        wr_entry;
    step_entry_t        rd_entry;

    assign in_kind      = item_kind_t'(s_tuser);
    assign in_slot      = s_tdata[3:0];
    assign in_step_kind = step_kind_t'(s_tdata[5:4]);
    assign in_tag       = s_tdata[11:6];
    assign in_duration  = s_tdata[43:12];

    // Output register frees up when drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(64 - RES_W)'(0), res_reg};

    // Step count clamped to the table size
    assign eff_count = (step_count_reg > COUNT_W'(MAX_STEPS)) ? COUNT_W'(MAX_STEPS)
                                                              : step_count_reg;
    // Index wraps to 0 if the count was lowered under it
    assign tick_idx  = ({1'b0, step_idx_reg} >= eff_count) ? '0 : step_idx_reg;
    assign tag_known = ({1'b0, rd_entry.tag} < (TAG_W+1)'(TAG_COUNT));

    // Any sound step below the count needs the player
    always_comb begin
        needs_player = 1'b0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if ((COUNT_W'(i) < eff_count) && sound_mask_reg[i]) begin
                needs_player = 1'b1;
            end
        end
    end

    assign start_ok = !((!player_ready_reg && needs_player) || (eff_count == '0));
    assign start_refused = s_fire && (in_kind == ITEM_START) && !start_ok;
    assign write_ok = (in_step_kind != STEP_INVALID) && (in_duration != '0)
                   && ({1'b0, in_slot} < COUNT_W'(MAX_STEPS));

    // Table write path
    assign wr_en             = s_fire && (in_kind == ITEM_WRITE) && write_ok;
    assign wr_entry.kind     = in_step_kind;
    assign wr_entry.tag      = (in_step_kind == STEP_PAUSE) ? '0 : in_tag;
    assign wr_entry.duration = in_duration;

    tss_step_table u_table (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_slot  (in_slot),
        .wr_entry (wr_entry),
        .rd_slot  (tick_idx),
        .rd_entry (rd_entry)
    );

    // Single-pass state update and result
    always_comb begin
        running_next    = running_reg;
        active_next     = active_reg;
        step_idx_next   = step_idx_reg;
        elapsed_next    = elapsed_reg;
        volume_next     = volume_reg;
        sound_mask_next = sound_mask_reg;
        el_cur          = elapsed_reg;
        idx_inc         = {1'b0, tick_idx} + COUNT_W'(1);
        res             = '0;
        res.accepted    = 1'b1;

        if (s_fire) begin
            unique case (in_kind)
                ITEM_TICK: begin
                    if (running_reg) begin
                        if (eff_count == '0) begin
                            running_next = 1'b0;
                        end else begin
                            step_idx_next = tick_idx;
                            if (!active_reg) begin
                                // first tick of a step issues its commands
                                unique case (rd_entry.kind)
                                    STEP_ULTRA: begin
                                        res.stop_player = player_ready_reg;
                                        if (tag_known) begin
                                            res.play_ultrasound = 1'b1;
                                            res.sound_tag       = rd_entry.tag;
                                            res.play_duration   = rd_entry.duration;
                                        end
                                    end
                                    STEP_SOUND: begin
                                        res.stop_ultrasound = 1'b1;
                                        if (player_ready_reg && tag_known) begin
                                            res.play_sound = 1'b1;
                                            res.sound_tag  = rd_entry.tag;
                                        end
                                    end
                                    STEP_PAUSE, STEP_INVALID: begin
                                        res.stop_ultrasound = 1'b1;
                                        res.stop_player     = 1'b1;
                                    end
                                endcase
                                active_next = 1'b1;
                                el_cur      = '0;
                            end else if (elapsed_reg != '1) begin
                                el_cur = elapsed_reg + DUR_W'(1);
                            end
                            elapsed_next = el_cur;
                            // step done: advance modulo the count
                            if (el_cur >= rd_entry.duration) begin
                                step_idx_next = (idx_inc >= eff_count) ? '0
                                                                       : idx_inc[SLOT_W-1:0];
                                active_next   = 1'b0;
                            end
                        end
                    end
                end
                ITEM_START: begin
                    volume_next    = pct_to_volume(start_pct_reg);
                    res.set_volume = player_ready_reg;
                    if (start_ok) begin
                        running_next  = 1'b1;
                        step_idx_next = '0;
                        active_next   = 1'b0;
                        elapsed_next  = '0;
                    end else begin
                        res.accepted = 1'b0;
                    end
                end
                ITEM_STOP: begin
                    running_next        = 1'b0;
                    active_next         = 1'b0;
                    res.stop_ultrasound = 1'b1;
                    res.stop_player     = player_ready_reg;
                end
                ITEM_WRITE: begin
                    if (write_ok) begin
                        running_next             = 1'b0;
                        active_next              = 1'b0;
                        step_idx_next            = '0;
                        elapsed_next             = '0;
                        sound_mask_next[in_slot] = (in_step_kind == STEP_SOUND);
                        res.stop_ultrasound      = 1'b1;
                        res.stop_player          = player_ready_reg;
                    end else begin
                        res.accepted = 1'b0;
                    end
                end
            endcase
        end

        // always-reported fields
        res.volume_level     = volume_next;
        res.ultrasound_level = volume_to_level(volume_next);
        res.running          = running_next;
        res.current_step     = step_idx_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg   <= '0;
            start_pct_reg    <= START_PCT_RESET;
            player_ready_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEP_COUNT:   step_count_reg   <= cfg_wdata[COUNT_W-1:0];
                CFG_START_VOLUME: start_pct_reg    <= cfg_wdata[PCT_W-1:0];
                CFG_PLAYER_READY: player_ready_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            active_reg     <= 1'b0;
            step_idx_reg   <= '0;
            elapsed_reg    <= '0;
            volume_reg     <= VOLUME_RESET;
            sound_mask_reg <= '0;
        end else begin
            running_reg    <= running_next;
            active_reg     <= active_next;
            step_idx_reg   <= step_idx_next;
            elapsed_reg    <= elapsed_next;
            volume_reg     <= volume_next;
            sound_mask_reg <= sound_mask_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res;
        end
    end

    // Checks
    `TSS_ASSERT_NEXT(a_write_rewinds, wr_en, (!running_reg && (step_idx_reg == '0)))
    `TSS_ASSERT_NEXT(a_refused_start_holds, start_refused, (running_reg == $past(running_reg)))
    `TSS_ASSERT_NOW(a_sound_needs_player, (m_tvalid_reg && res_reg.play_sound), player_ready_reg)
    `TSS_ASSERT_NOW(a_one_play, m_tvalid_reg, !(res_reg.play_sound && res_reg.play_ultrasound))

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for timed_step_sequencer: directed and random item streams,
// each result beat checked against an in-bench model of the sequencer.
// Depends on tss_pkg and the timed_step_sequencer RTL.

module tb_top;
    import tss_pkg::*;

    localparam int RANDOM_ITEMS   = 480;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    // One input beat, field by field
    typedef struct packed {
        item_kind_t  kind;
        logic [3:0]  slot;
        step_kind_t  skind;
        logic [5:0]  tag;
        logic [31:0] dur;
    } seq_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [3:0] step_slot, [5:4] step_kind, [11:6] step_tag, [43:12] step_duration
    logic [47:0]          s_tdata   = '0;
    // [1:0] kind
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [0] stop_ultrasound, [1] stop_player, [2] play_sound, [3] play_ultrasound,
    // [4] set_volume, [9:5] volume_level, [15:10] sound_tag,
    // [19:16] ultrasound_level, [51:20] play_duration, [52] accepted,
    // [53] running, [57:54] current_step
    logic [63:0]          m_tdata;

    timed_step_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model state and register copies
    logic [4:0]  cfg_count   = 5'd0;
    logic [6:0]  cfg_percent = 7'd33;
    logic        cfg_ready   = 1'b0;
    logic        run_on      = 1'b0;
    logic        step_live   = 1'b0;
    logic [3:0]  cur_step    = '0;
    logic [31:0] step_ticks  = '0;
    logic [4:0]  vol_now     = 5'd10;
    step_kind_t  tab_kind [16];
    logic [5:0]  tab_tag [16];
    logic [31:0] tab_duration [16];
    logic [15:0] sound_mask    = '0;
    logic [15:0] written_slots = '0;

    result_t pending_outputs[$];
    int      mismatches   = 0;
    int      beats_seen   = 0;
    int      burst_left   = 0;
    int      quiet_cycles = 0;

    // Receiver stall control
    int          hold_asked  = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    int          stall_mode  = 0;
    logic [1:0]  stall_phase = '0;

    // Advance the model by one accepted beat and return the result it must produce
    function automatic result_t next_sequencer_output(input seq_item_t it);
        result_t     r;
        int          n;
        int          pct;
        int          nxt;
        int          pct_back;
        logic [16:0] below;
        r = '0;
        r.accepted = 1'b1;
        n = (cfg_count > 16) ? 16 : int'(cfg_count);
        case (it.kind)
            ITEM_TICK: begin
                if (run_on) begin
                    if (n == 0) begin
                        run_on = 1'b0;
                    end else begin
                        if (cur_step >= n) cur_step = '0;
                        // first tick of a step issues its commands; tags always fit
                        if (!step_live) begin
                            case (tab_kind[cur_step])
                                STEP_ULTRA: begin
                                    r.stop_player     = cfg_ready;
                                    r.play_ultrasound = 1'b1;
                                    r.sound_tag       = tab_tag[cur_step];
                                    r.play_duration   = tab_duration[cur_step];
                                end
                                STEP_SOUND: begin
                                    r.stop_ultrasound = 1'b1;
                                    if (cfg_ready) begin
                                        r.play_sound = 1'b1;
                                        r.sound_tag  = tab_tag[cur_step];
                                    end
                                end
                                default: begin
                                    r.stop_ultrasound = 1'b1;
                                    r.stop_player     = 1'b1;
                                end
                            endcase
                            step_live  = 1'b1;
                            step_ticks = '0;
                        end else if (step_ticks != '1) begin
                            step_ticks = step_ticks + 1;
                        end
                        if (step_ticks >= tab_duration[cur_step]) begin
                            nxt       = int'(cur_step) + 1;
                            cur_step  = (nxt >= n) ? 4'd0 : 4'(nxt);
                            step_live = 1'b0;
                        end
                    end
                end
            end
            ITEM_START: begin
                pct = (cfg_percent > 100) ? 100 : int'(cfg_percent);
                vol_now = 5'((pct * 30 + 50) / 100);
                r.set_volume = cfg_ready;
                below = (17'd1 << n) - 17'd1;
                if (n == 0 || (!cfg_ready && |(sound_mask & below[15:0]))) begin
                    r.accepted = 1'b0;
                end else begin
                    run_on     = 1'b1;
                    cur_step   = '0;
                    step_live  = 1'b0;
                    step_ticks = '0;
                end
            end
            ITEM_STOP: begin
                run_on            = 1'b0;
                step_live         = 1'b0;
                r.stop_ultrasound = 1'b1;
                r.stop_player     = cfg_ready;
            end
            default: begin
                if (it.skind == STEP_INVALID || it.dur == '0) begin
                    r.accepted = 1'b0;
                end else begin
                    run_on                 = 1'b0;
                    step_live              = 1'b0;
                    r.stop_ultrasound      = 1'b1;
                    r.stop_player          = cfg_ready;
                    tab_kind[it.slot]      = it.skind;
                    tab_tag[it.slot]       = (it.skind == STEP_PAUSE) ? 6'd0 : it.tag;
                    tab_duration[it.slot]  = it.dur;
                    sound_mask[it.slot]    = (it.skind == STEP_SOUND);
                    written_slots[it.slot] = 1'b1;
                    cur_step               = '0;
                    step_ticks             = '0;
                end
            end
        endcase
        // volume -> percent -> level, both rounded
        pct_back           = (int'(vol_now) * 100 + 15) / 30;
        r.volume_level     = vol_now;
        r.ultrasound_level = 4'((pct_back * 10 + 50) / 100);
        r.running          = run_on;
        r.current_step     = cur_step;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     beats_seen, what, got, want);
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    // Result beat checker
    always @(posedge aclk) begin : result_check
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_outputs.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata, 0);
            end else begin
                want = pending_outputs.pop_front();
                check_field("stop_ultrasound", seen.stop_ultrasound, want.stop_ultrasound);
                check_field("stop_player", seen.stop_player, want.stop_player);
                check_field("play_sound", seen.play_sound, want.play_sound);
                check_field("play_ultrasound", seen.play_ultrasound, want.play_ultrasound);
                check_field("set_volume", seen.set_volume, want.set_volume);
                check_field("volume_level", seen.volume_level, want.volume_level);
                check_field("sound_tag", seen.sound_tag, want.sound_tag);
                check_field("ultrasound_level", seen.ultrasound_level, want.ultrasound_level);
                check_field("play_duration", seen.play_duration, want.play_duration);
                check_field("accepted", seen.accepted, want.accepted);
                check_field("running", seen.running, want.running);
                check_field("current_step", seen.current_step, want.current_step);
            end
            beats_seen++;
        end
    end

    // Receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(10, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            stall_phase <= stall_phase + 2'd1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_phase == 2'd0);
                default: m_tready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timed_step_sequencer regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one beat in bursts with random gaps; predict at acceptance
    task automatic send_item(input seq_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                if (s_tvalid) s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        if (!s_tvalid) s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {4'b0, it.dur, it.tag, it.skind, it.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outputs.push_back(next_sequencer_output(it));
        burst_left--;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle
    task automatic set_config(input logic [4:0] count, input logic [6:0] pct,
                              input logic ready);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEP_COUNT;
        cfg_wdata <= 7'(count);
        @(posedge aclk);
        cfg_index <= CFG_START_VOLUME;
        cfg_wdata <= pct;
        @(posedge aclk);
        cfg_index <= CFG_PLAYER_READY;
        cfg_wdata <= 7'(ready);
        @(posedge aclk);
        cfg_we      <= 1'b0;
        cfg_count   = count;
        cfg_percent = pct;
        cfg_ready   = ready;
    endtask

    function automatic seq_item_t make_item(input item_kind_t kind, input logic [3:0] slot,
                                            input step_kind_t skind, input logic [5:0] tag,
                                            input logic [31:0] dur);
        seq_item_t it;
        it.kind  = kind;
        it.slot  = slot;
        it.skind = skind;
        it.tag   = tag;
        it.dur   = dur;
        return it;
    endfunction

    // Any kind with fully random payload fields
    function automatic seq_item_t random_item(input item_kind_t kind);
        return make_item(kind, 4'($urandom), step_kind_t'($urandom_range(0, 3)),
                         6'($urandom), $urandom);
    endfunction

    // Well-formed step write; long durations only when allowed
    function automatic seq_item_t write_step(input logic [3:0] slot, input bit long_ok);
        logic [31:0] dur;
        dur = (long_ok && $urandom_range(0, 9) == 0) ? ($urandom | 32'h1)
                                                      : 32'($urandom_range(1, 4));
        return make_item(ITEM_WRITE, slot, step_kind_t'($urandom_range(0, 2)),
                         6'($urandom), dur);
    endfunction

    task automatic test_idle_state();
        send_item(random_item(ITEM_TICK));   // tick while stopped
        send_item(random_item(ITEM_START));  // refused, count is zero
    endtask

    task automatic test_step_writes();
        send_item(make_item(ITEM_WRITE, 4'd4, STEP_INVALID, 6'd9, 32'd3));
        send_item(make_item(ITEM_WRITE, 4'd4, STEP_SOUND, 6'd9, 32'd0));
        send_item(make_item(ITEM_WRITE, 4'd0, STEP_PAUSE, 6'd5, 32'd1));
        send_item(make_item(ITEM_WRITE, 4'd1, STEP_SOUND, 6'd63, 32'd2));
        send_item(make_item(ITEM_WRITE, 4'd2, STEP_ULTRA, 6'd63, 32'hFFFF_FFFF));
        send_item(make_item(ITEM_WRITE, 4'd2, STEP_ULTRA, 6'd0, 32'd1));
        send_item(make_item(ITEM_WRITE, 4'd3, STEP_SOUND, 6'd0, 32'd1));
        send_item(make_item(ITEM_WRITE, 4'd15, STEP_PAUSE, 6'd63, 32'd2));
    endtask

    task automatic test_start_needs_player();
        set_config(5'd4, 7'd0, 1'b0);
        send_item(random_item(ITEM_START));  // sound step below count, no player
    endtask

    task automatic test_loop_playback();
        set_config(5'd4, 7'd100, 1'b1);
        send_item(random_item(ITEM_START));
        repeat (8) send_item(random_item(ITEM_TICK));
        send_item(random_item(ITEM_START));  // restart while running
        send_item(random_item(ITEM_TICK));
        send_item(random_item(ITEM_STOP));
        send_item(random_item(ITEM_TICK));
    endtask

    task automatic test_write_while_running();
        send_item(random_item(ITEM_START));
        repeat (2) send_item(random_item(ITEM_TICK));
        send_item(make_item(ITEM_WRITE, 4'd0, STEP_PAUSE, 6'd17, 32'd1));
        send_item(random_item(ITEM_TICK));
    endtask

    task automatic test_count_change();
        int guard;
        set_config(5'd4, 7'd127, 1'b1);
        send_item(random_item(ITEM_START));
        guard = 0;
        while (cur_step != 4'd3 && guard < 20) begin
            send_item(random_item(ITEM_TICK));
            guard++;
        end
        // index now beyond the lowered count: wraps to the first step
        set_config(5'd2, 7'd127, 1'b1);
        send_item(random_item(ITEM_TICK));
        // zero count while running: the next tick stops quietly
        set_config(5'd0, 7'd127, 1'b1);
        send_item(random_item(ITEM_TICK));
    endtask

    task automatic test_output_stall();
        set_config(5'd4, 7'd50, 1'b1);
        send_item(random_item(ITEM_START));
        hold_asked++;
        repeat (24) send_item(random_item(ITEM_TICK));
    endtask

    task automatic test_random_phases();
        int          counted;
        int          roll;
        int          n;
        logic [4:0]  count;
        logic [6:0]  pct;
        seq_item_t   it;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)      count = 5'd0;
            else if (roll == 1) count = 5'($urandom_range(17, 31));
            else if (roll == 2) count = 5'd16;
            else                count = 5'($urandom_range(1, 15));
            roll = $urandom_range(0, 9);
            if (roll == 0)      pct = 7'd0;
            else if (roll == 1) pct = 7'd100;
            else if (roll == 2) pct = 7'd127;
            else                pct = 7'($urandom);
            set_config(count, pct, ($urandom_range(0, 3) != 0));
            // every slot the loop can reach must hold a step
            n = (count > 16) ? 16 : int'(count);
            for (int s = 0; s < n; s++) begin
                if (!written_slots[s]) begin
                    send_item(write_step(4'(s), 1'b0));
                    counted++;
                end
            end
            repeat ($urandom_range(0, 3)) begin
                send_item(write_step(4'($urandom), 1'b1));
                counted++;
            end
            send_item(random_item(ITEM_START));
            counted++;
            repeat ($urandom_range(15, 50)) begin
                roll = $urandom_range(0, 99);
                if (!run_on && $urandom_range(0, 3) == 0) begin
                    it = random_item(ITEM_START);
                end else if (roll < 84) begin
                    it = random_item(ITEM_TICK);
                end else if (roll < 88) begin
                    it = random_item(ITEM_STOP);
                end else if (roll < 92) begin
                    it = random_item(ITEM_START);
                end else if (roll < 97) begin
                    it = write_step(4'($urandom), 1'b1);
                end else begin
                    // malformed write: bad kind or zero length
                    it = random_item(ITEM_WRITE);
                    if ($urandom_range(0, 1) == 0) it.dur = '0;
                    else                           it.skind = STEP_INVALID;
                end
                counted++;
                send_item(it);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_state();
        test_step_writes();
        test_start_needs_player();
        test_loop_playback();
        test_write_while_running();
        test_count_change();
        test_output_stall();
        test_random_phases();

        drain_results();
        repeat (4) @(posedge aclk);
        if (pending_outputs.size() != 0)
            report_mismatch("results never delivered", pending_outputs.size(), 0);
        if (mismatches == 0) begin
            $display("timed_step_sequencer regression: pass");
        end else begin
            $display("timed_step_sequencer regression: fail");
        end
        $finish;
    end

endmodule
